// ----- rtl/epr_pkg.sv -----
// epr_pkg: shared types, constants and the mixing function of the entropy pool ring
// used by rtl/epr_pool.sv and rtl/entropy_pool_ring.sv; no dependencies

package epr_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned POOL_DEPTH_DEF  = 8;
    localparam int unsigned AVAIL_W         = 3;
    localparam int unsigned MIX_ROT         = 3;
    localparam logic [BYTE_W-1:0] THRESH_RESET = 8'd127;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    // rotate left by three, then fold in the new sample
    function automatic logic [BYTE_W-1:0] mix_byte(
        input logic [BYTE_W-1:0] old_byte,
        input logic [BYTE_W-1:0] smp
    );
        logic [BYTE_W-1:0] rot;
        rot = {old_byte[BYTE_W-1-MIX_ROT:0], old_byte[BYTE_W-1:BYTE_W-MIX_ROT]};
        return rot ^ smp;
    endfunction

endpackage

// ----- rtl/entropy_pool_ring.sv -----
// entropy_pool_ring: top level of the entropy pool ring (push/pop front end,
// ring pointers, quality score, result register); depends on epr_pkg and epr_pool
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+----------------------------------------
//   s_       | in  | s_valid / s_ready  | s_cmd, s_sample, s_weight
//   m_       | out | m_valid / m_ready  | m_random_byte, m_byte_valid, m_available
//   cfg_     | in  | cfg_wr_en          | cfg_wr_data (commit threshold)
//
// one request per cycle sustained while m_ is not stalled: the pool read registers on the
// accept edge, mix/writeback and the result register load as the stage advances, head, count
// and score update on the accept edge, so back-to-back requests never wait
// a stalled m_ holds the result register and the stage behind it, then s_ready drops
// reset is synchronous active low; the pool valid bits clear at once, no clearing pass

module entropy_pool_ring #(
    parameter int unsigned POOL_DEPTH = epr_pkg::POOL_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [epr_pkg::BYTE_W-1:0]    cfg_wr_data,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  epr_pkg::cmd_t                 s_cmd,
    input  logic [epr_pkg::BYTE_W-1:0]    s_sample,
    input  logic [epr_pkg::BYTE_W-1:0]    s_weight,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [epr_pkg::BYTE_W-1:0]    m_random_byte,
    output logic                          m_byte_valid,
    output logic [epr_pkg::AVAIL_W-1:0]   m_available
);
    import epr_pkg::*;

    localparam int unsigned AW = $clog2(POOL_DEPTH);
    localparam logic [AW-1:0] LAST_IDX   = AW'(POOL_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_WIDE = (AW+1)'(POOL_DEPTH);

    // configuration and ring state
    logic [BYTE_W-1:0] thresh_reg;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0] score_reg, score_next;

    // front-end decode
    logic              accept;
    logic [AW:0]       slot_base, slot_plus;
    logic [AW-1:0]     slot_base_wr, slot_plus_wr;
    logic [AW-1:0]     addr;
    logic              pop_hit;
    logic [2*BYTE_W-1:0] weight_sq;
    logic [AW+AVAIL_W-1:0] count_ext;

    // mix stage
    logic              stg_valid_reg;
    cmd_t              stg_cmd_reg;
    logic [BYTE_W-1:0] stg_sample_reg;
    logic [AW-1:0]     stg_addr_reg;
    logic              stg_hit_reg;
    logic [AVAIL_W-1:0] stg_avail_reg;
    logic              stg_adv;
    logic [BYTE_W-1:0] pool_rd_data;
    logic              pool_wr_en;
    logic [BYTE_W-1:0] pool_wr_data;

    // result register
    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic              m_bvalid_reg;
    logic [AVAIL_W-1:0] m_avail_reg;

    // handshake: the stage moves when the result register is free or being drained
    assign stg_adv = stg_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stg_valid_reg || stg_adv;
    assign accept  = s_valid && s_ready;

    // commit threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            thresh_reg <= cfg_wr_data;
        end
    end

    // filling slot sits at head+count, the slot after it at head+count+1
    assign weight_sq    = s_weight * s_weight;
    assign slot_base    = {1'b0, head_reg} + {1'b0, count_reg};
    assign slot_plus    = slot_base + (AW+1)'(1);
    assign slot_base_wr = (slot_base >= DEPTH_WIDE) ? AW'(slot_base - DEPTH_WIDE)
                                                    : AW'(slot_base);
    assign slot_plus_wr = (slot_plus >= DEPTH_WIDE) ? AW'(slot_plus - DEPTH_WIDE)
                                                    : AW'(slot_plus);

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        score_next = score_reg;
        addr       = head_reg;
        pop_hit    = 1'b0;
        unique case (s_cmd)
            CMD_PUSH: begin
                if (score_reg < thresh_reg) begin
                    // still collecting quality: keep mixing into the filling slot
                    score_next = score_reg + weight_sq[BYTE_W-1:0];
                    addr       = slot_base_wr;
                end else if (count_reg != LAST_IDX) begin
                    // commit the filling slot and start the next one
                    addr       = slot_plus_wr;
                    count_next = count_reg + AW'(1);
                    score_next = '0;
                end else begin
                    // ring full: fold into the oldest committed byte, score kept
                    addr = head_reg;
                end
            end
            CMD_POP: begin
                if (count_reg != '0) begin
                    pop_hit    = 1'b1;
                    addr       = head_reg;
                    head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
                    count_next = count_reg - AW'(1);
                end
            end
            default: begin
                addr = head_reg;
            end
        endcase
    end

    assign count_ext = (AW+AVAIL_W)'(count_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            score_reg <= '0;
        end else if (accept) begin
            head_reg  <= head_next;
            count_reg <= count_next;
            score_reg <= score_next;
        end
    end

    // mix stage: holds the request while the pool read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (accept) begin
            stg_valid_reg <= 1'b1;
        end else if (stg_adv) begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_cmd_reg    <= s_cmd;
            stg_sample_reg <= s_sample;
            stg_addr_reg   <= addr;
            stg_hit_reg    <= pop_hit;
            stg_avail_reg  <= count_ext[AVAIL_W-1:0];
        end
    end

    // pool write happens when the push leaves the stage
    assign pool_wr_en   = stg_adv && (stg_cmd_reg == CMD_PUSH);
    assign pool_wr_data = mix_byte(pool_rd_data, stg_sample_reg);

    epr_pool #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_pool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (addr),
        .wr_en   (pool_wr_en),
        .wr_addr (stg_addr_reg),
        .wr_data (pool_wr_data),
        .rd_data (pool_rd_data)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stg_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_adv) begin
            m_byte_reg   <= stg_hit_reg ? pool_rd_data : '0;
            m_bvalid_reg <= stg_hit_reg;
            m_avail_reg  <= stg_avail_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_random_byte = m_byte_reg;
    assign m_byte_valid  = m_bvalid_reg;
    assign m_available   = m_avail_reg;

endmodule

// ----- rtl/epr_pool.sv -----
// epr_pool: byte store of the ring with per-entry valid bits, registered read
// and a one-deep write bypass; depends on epr_pkg

module epr_pool #(
    parameter int unsigned POOL_DEPTH = epr_pkg::POOL_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rd_en,
    input  logic [$clog2(POOL_DEPTH)-1:0]       rd_addr,
    input  logic                                wr_en,
    input  logic [$clog2(POOL_DEPTH)-1:0]       wr_addr,
    input  logic [epr_pkg::BYTE_W-1:0]          wr_data,
    output logic [epr_pkg::BYTE_W-1:0]          rd_data
);
    import epr_pkg::*;

    localparam int unsigned AW = $clog2(POOL_DEPTH);

    logic [BYTE_W-1:0]     mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0] vld_reg;
    logic [BYTE_W-1:0]     rd_raw_reg;
    logic                  rd_vld_reg;
    logic [AW-1:0]         rd_addr_reg;
    logic                  lw_valid_reg;
    logic [AW-1:0]         lw_addr_reg;
    logic [BYTE_W-1:0]     lw_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_raw_reg  <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // last write, to cover a read taken on the same edge as that write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_valid_reg <= 1'b0;
        end else if (wr_en) begin
            lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    always_comb begin
        if (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) begin
            rd_data = lw_data_reg;
        end else if (rd_vld_reg) begin
            rd_data = rd_raw_reg;
        end else begin
            rd_data = '0;
        end
    end

endmodule

// ----- dv/epr_ring_checker.sv -----
// epr_ring_checker: watches both channels of the entropy pool ring, predicts each
// result from the accepted requests and compares field by field; depends on epr_pkg

module epr_ring_checker #(
    parameter int unsigned DEPTH = epr_pkg::POOL_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [epr_pkg::BYTE_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  epr_pkg::cmd_t                  s_cmd,
    input  logic [epr_pkg::BYTE_W-1:0]     s_sample,
    input  logic [epr_pkg::BYTE_W-1:0]     s_weight,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [epr_pkg::BYTE_W-1:0]     m_random_byte,
    input  logic                           m_byte_valid,
    input  logic [epr_pkg::AVAIL_W-1:0]    m_available,
    output int unsigned                    due_count,
    output int unsigned                    mismatch_count
);
    import epr_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0]  random_byte;
        logic               byte_valid;
        logic [AVAIL_W-1:0] available;
    } pool_result_t;

    logic [BYTE_W-1:0] ring [DEPTH];
    logic [BYTE_W-1:0] quality;
    logic [BYTE_W-1:0] threshold;
    int unsigned       head_idx;
    int unsigned       fill_cnt;
    pool_result_t      due_results [$];
    int unsigned       due_n = 0;
    int unsigned       errs = 0;

    assign due_count      = due_n;
    assign mismatch_count = errs;

    function automatic logic [BYTE_W-1:0] rot3(input logic [BYTE_W-1:0] b);
        return {b[BYTE_W-4:0], b[BYTE_W-1:BYTE_W-3]};
    endfunction

    // advance the pool by one request and return the result it yields
    function automatic pool_result_t apply_request(
        input cmd_t              cmd,
        input logic [BYTE_W-1:0] smp,
        input logic [BYTE_W-1:0] w
    );
        pool_result_t r;
        int unsigned  slot;
        logic [15:0]  sq;
        r = '0;
        if (cmd == CMD_PUSH) begin
            slot = head_idx + fill_cnt;
            sq   = w * w;
            if (quality < threshold) begin
                quality = quality + sq[BYTE_W-1:0];
            end else if (fill_cnt < DEPTH - 1) begin
                slot     = slot + 1;
                fill_cnt = fill_cnt + 1;
                quality  = '0;
            end else begin
                // full ring: fold into the oldest committed byte
                slot = head_idx;
            end
            slot       = slot % DEPTH;
            ring[slot] = rot3(ring[slot]) ^ smp;
        end else if (fill_cnt != 0) begin
            r.random_byte = ring[head_idx];
            r.byte_valid  = 1'b1;
            head_idx      = (head_idx + 1) % DEPTH;
            fill_cnt      = fill_cnt - 1;
        end
        r.available = AVAIL_W'(fill_cnt);
        return r;
    endfunction

    always @(posedge aclk) begin
        pool_result_t want;
        if (!aresetn) begin
            foreach (ring[i]) ring[i] = '0;
            quality   = '0;
            threshold = THRESH_RESET;
            head_idx  = 0;
            fill_cnt  = 0;
            due_results.delete();
        end else begin
            if (cfg_wr_en)
                threshold = cfg_wr_data;
            if (s_valid && s_ready)
                due_results.push_back(apply_request(s_cmd, s_sample, s_weight));
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no request outstanding: byte %0h valid %0b avail %0d",
                           m_random_byte, m_byte_valid, m_available);
                    errs++;
                end else begin
                    want = due_results.pop_front();
                    if (m_random_byte !== want.random_byte) begin
                        $error("random_byte: expected %0h, actual %0h",
                               want.random_byte, m_random_byte);
                        errs++;
                    end
                    if (m_byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0b, actual %0b",
                               want.byte_valid, m_byte_valid);
                        errs++;
                    end
                    if (m_available !== want.available) begin
                        $error("available: expected %0d, actual %0d",
                               want.available, m_available);
                        errs++;
                    end
                end
            end
        end
        due_n <= due_results.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// tb_top: stimulus and verdict for the entropy pool ring; drives requests, results
// backpressure and threshold writes; depends on epr_pkg, entropy_pool_ring, epr_ring_checker

module tb_top;
    import epr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned PHASES      = 7;
    localparam int unsigned PHASE_ITEMS = 150;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [BYTE_W-1:0]   cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    cmd_t                s_cmd       = CMD_PUSH;
    logic [BYTE_W-1:0]   s_sample    = '0;
    logic [BYTE_W-1:0]   s_weight    = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [BYTE_W-1:0]   m_random_byte;
    logic                m_byte_valid;
    logic [AVAIL_W-1:0]  m_available;

    int unsigned due_count;
    int unsigned mismatch_count;
    int unsigned cycle_cnt = 0;

    // idle-free stretches for either side, and a request for one long receiver hold
    bit tx_burst    = 1'b0;
    bit rx_burst    = 1'b0;
    bit rx_hold_req = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    entropy_pool_ring u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_sample      (s_sample),
        .s_weight      (s_weight),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_byte (m_random_byte),
        .m_byte_valid  (m_byte_valid),
        .m_available   (m_available)
    );

    epr_ring_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_sample       (s_sample),
        .s_weight       (s_weight),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_byte  (m_random_byte),
        .m_byte_valid   (m_byte_valid),
        .m_available    (m_available),
        .due_count      (due_count),
        .mismatch_count (mismatch_count)
    );

    // watchdog: the slowest legal run is far below this
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("entropy_pool_ring verification failed");
            $finish;
        end
    end

    // offer one request, after a random gap (none in a burst), and return at the edge that takes it
    // valid stays high when the next request follows with no gap
    task automatic send_request(
        input cmd_t              cmd,
        input logic [BYTE_W-1:0] smp,
        input logic [BYTE_W-1:0] w
    );
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_sample <= smp;
        s_weight <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait until every predicted result has been taken
    task automatic drain_pool_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
    endtask

    // threshold writes only land on an idle block
    task automatic write_threshold(input logic [BYTE_W-1:0] value);
        drain_pool_results();
        repeat (3) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] phase_threshold(input int unsigned ph);
        case (ph)
            0:       return 8'd255;
            1:       return 8'd1;
            2:       return 8'd60;
            3:       return 8'd0;
            4:       return 8'd200;
            5:       return 8'd127;
            default: return BYTE_W'($urandom_range(2, 254));
        endcase
    endfunction

    function automatic int unsigned phase_pop_pct(input int unsigned ph);
        case (ph)
            0:       return 15;
            1:       return 40;
            2:       return 25;
            3:       return 45;
            4:       return 10;
            5:       return 60;
            default: return 35;
        endcase
    endfunction

    // result side: a freshly drawn stall (possibly none) before every result, plus one long hold on request
    initial begin
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                // long hold so the pipeline fills and s_ready drops
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold_req = 1'b0;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        int unsigned       pop_pct;
        cmd_t              cmd;
        logic [BYTE_W-1:0] w;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pop, weight extremes, score crossing the reset threshold
        send_request(CMD_POP,  8'hff, 8'hff);
        send_request(CMD_PUSH, 8'hff, 8'h00);
        send_request(CMD_PUSH, 8'h00, 8'hff);
        send_request(CMD_PUSH, 8'ha5, 8'h0c);
        send_request(CMD_PUSH, 8'h5a, 8'h00);
        send_request(CMD_POP,  8'h00, 8'h00);
        send_request(CMD_POP,  8'hff, 8'hff);

        // zero threshold: every push commits until the ring is full, then the
        // extra pushes fold into the oldest byte; pops drain it down to an empty pop
        write_threshold(8'd0);
        for (int i = 0; i < 9; i++)
            send_request(CMD_PUSH, (i % 2 != 0) ? 8'hff : 8'h00, 8'hff);
        for (int i = 0; i < 8; i++)
            send_request(CMD_POP, 8'h00, 8'h00);

        // random phases, each under its own threshold
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            write_threshold(phase_threshold(ph));
            pop_pct = phase_pop_pct(ph);
            for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
                if (ph == 2 && i == 10) begin
                    // receiver holds off while the sender keeps offering
                    rx_hold_req = 1'b1;
                    tx_burst    = 1'b1;
                    rx_burst    = 1'b0;
                end else if (i % 40 == 0 && !(ph == 2 && i < 80)) begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                // sender pauses until the pipeline is empty
                if (ph == 4 && i == 75)
                    drain_pool_results();
                cmd = ($urandom_range(0, 99) < pop_pct) ? CMD_POP : CMD_PUSH;
                // small weights keep the score climbing slowly
                w = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 3))
                                                : BYTE_W'($urandom);
                send_request(cmd, BYTE_W'($urandom), w);
            end
        end

        drain_pool_results();
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0 && due_count == 0) begin
            $display("entropy_pool_ring verification clean");
        end else begin
            $display("entropy_pool_ring verification failed");
        end
        $finish;
    end

endmodule
